// ===== src/d8ra_pkg.sv =====
// ----------------------------------------------------------------------------
// d8ra_pkg
// shared constants, command codes and the saturating add helper of the d8 runoff
// accumulator
// ----------------------------------------------------------------------------
package d8ra_pkg;

    // table sizes
    localparam int MAX_CELLS  = 4096;
    localparam int MAX_BASINS = 256;
    localparam int CELL_AW    = $clog2(MAX_CELLS);
    localparam int BASIN_AW   = $clog2(MAX_BASINS);

    // field widths
    localparam int CMD_W   = 3;
    localparam int CIDX_W  = 12;
    localparam int DEPTH_W = 24;
    localparam int AREA_W  = 32;
    localparam int SUB_W   = 8;
    localparam int FLOW_W  = 48;
    localparam int SCALE_W = 32;
    localparam int PROD_W  = DEPTH_W + AREA_W;
    localparam int LO_W    = 32;
    localparam int HI_W    = PROD_W - LO_W;
    localparam int MHI_W   = HI_W + SCALE_W;
    localparam int MLO_W   = LO_W + SCALE_W;

    // cell table entry: flow, basin, wet mark
    localparam int CELL_W = FLOW_W + SUB_W + 1;

    // config port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_FLOW_SCALE = '0;
    localparam logic [SCALE_W-1:0] SCALE_RESET    = 32'd12726;

    // command codes
    localparam logic [CMD_W-1:0] CMD_OPEN     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UPSTREAM = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLOSE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

    // result kinds
    localparam logic KIND_CELL  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [FLOW_W-1:0] FLOW_MAX = '1;

    // controller to datapath commands
    typedef struct packed {
        logic acc_open;
        logic acc_up;
        logic acc_close;
        logic acc_query;
        logic acc_clear;
        logic st_mul;
        logic st_sum;
        logic st_up;
        logic st_close;
        logic st_query;
    } t_dp_cmd;

    // saturating flow add
    function automatic logic [FLOW_W-1:0] sat_add(input logic [FLOW_W-1:0] a,
                                                  input logic [FLOW_W-1:0] b);
        logic [FLOW_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[FLOW_W] ? FLOW_MAX : s[FLOW_W-1:0];
    endfunction

endpackage

// ===== src/d8_runoff_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// d8_runoff_accumulator_core
// d8 flow accumulation engine: cells are opened, fed with upstream flows,
// closed into per-reach basin sums and the watershed sum, and queried
// ----------------------------------------------------------------------------
//
// channel  | handshake                         | payload
// ---------+-----------------------------------+-------------------------------
// command  | i_start, o_busy (beat: start&!busy)| cmd, cell_index, depth, area,
//          |                                   | subbasin, reach
// result   | o_valid strobe, one cycle         | kind, index, flow
// config   | apb psel/penable/pwrite, pready=1 | paddr, pwdata, prdata
//
// an open steps through depth*area, then two scale products, then the
//   add and saturate; upstream and close each wait on a registered table
//   read, query on the query state, and clear leaves the block idle; a
//   close result shows in the cycle after its beat, a query result is
//   registered from the query state; the multiplier chain and the
//   registered reads of the cell and basin tables set these steps
// reset is synchronous and active low; basin sums and the watershed sum
//   read zero right after reset or a clear (per-basin valid bits)
// results are never held off by the receiver
//
module d8_runoff_accumulator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command channel
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [d8ra_pkg::CMD_W-1:0]     i_cmd,
    input  logic [d8ra_pkg::CIDX_W-1:0]    i_cell_index,
    input  logic [d8ra_pkg::DEPTH_W-1:0]   i_runoff_depth,
    input  logic [d8ra_pkg::AREA_W-1:0]    i_cell_area,
    input  logic [d8ra_pkg::SUB_W-1:0]     i_subbasin,
    input  logic [d8ra_pkg::SUB_W-1:0]     i_reach,
    // result channel
    output logic                           o_valid,
    output logic                           o_kind,
    output logic [d8ra_pkg::CIDX_W-1:0]    o_index,
    output logic [d8ra_pkg::FLOW_W-1:0]    o_flow,
    // config port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [d8ra_pkg::PADDR_W-1:0]   paddr,
    input  logic [d8ra_pkg::PDATA_W-1:0]   pwdata,
    output logic [d8ra_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    logic [d8ra_pkg::SCALE_W-1:0] r_flow_scale;
    logic                         reg_hit;
    logic                         cfg_wr;
    d8ra_pkg::t_dp_cmd            dp_cmd;

    // one register, word address taken above the byte lane bits
    assign reg_hit = (paddr[d8ra_pkg::PADDR_W-1:2] == d8ra_pkg::REG_FLOW_SCALE);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow_scale <= d8ra_pkg::SCALE_RESET;
        end else if (cfg_wr && reg_hit) begin
            r_flow_scale <= pwdata;
        end
    end

    // reads outside the register map return zero
    assign prdata = reg_hit ? r_flow_scale : '0;

    // sequencer
    d8ra_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_cmd),
        .o_busy   (o_busy),
        .o_dp_cmd (dp_cmd)
    );

    // tables, sums and flow arithmetic
    d8ra_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_dp_cmd       (dp_cmd),
        .i_flow_scale   (r_flow_scale),
        .i_cell_index   (i_cell_index),
        .i_runoff_depth (i_runoff_depth),
        .i_cell_area    (i_cell_area),
        .i_subbasin     (i_subbasin),
        .i_reach        (i_reach),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_index        (o_index),
        .o_flow         (o_flow)
    );

endmodule

// ===== src/d8ra_ram.sv =====
// ----------------------------------------------------------------------------
// d8ra_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module d8ra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/d8ra_ctrl.sv =====
// ----------------------------------------------------------------------------
// d8ra_ctrl
// command sequencer: decodes accepted commands and steps the datapath
// ----------------------------------------------------------------------------
module d8ra_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [d8ra_pkg::CMD_W-1:0] i_cmd,
    output logic                     o_busy,
    output d8ra_pkg::t_dp_cmd        o_dp_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_SUM   = 6'b000100,
        S_UP    = 6'b001000,
        S_CLOSE = 6'b010000,
        S_QUERY = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign accept = i_start && (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        d8ra_pkg::CMD_OPEN: begin
                            o_dp_cmd.acc_open = 1'b1;
                            n_state = S_MUL;
                        end
                        d8ra_pkg::CMD_UPSTREAM: begin
                            o_dp_cmd.acc_up = 1'b1;
                            n_state = S_UP;
                        end
                        d8ra_pkg::CMD_CLOSE: begin
                            o_dp_cmd.acc_close = 1'b1;
                            n_state = S_CLOSE;
                        end
                        d8ra_pkg::CMD_QUERY: begin
                            o_dp_cmd.acc_query = 1'b1;
                            n_state = S_QUERY;
                        end
                        d8ra_pkg::CMD_CLEAR: begin
                            o_dp_cmd.acc_clear = 1'b1;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_MUL: begin
                o_dp_cmd.st_mul = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_dp_cmd.st_sum = 1'b1;
                n_state = S_IDLE;
            end
            S_UP: begin
                o_dp_cmd.st_up = 1'b1;
                n_state = S_IDLE;
            end
            S_CLOSE: begin
                o_dp_cmd.st_close = 1'b1;
                n_state = S_IDLE;
            end
            S_QUERY: begin
                o_dp_cmd.st_query = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== src/d8ra_dp.sv =====
// ----------------------------------------------------------------------------
// d8ra_dp
// datapath: open cell registers, flow multiplier chain, cell and basin
// tables, sums and result register
// ----------------------------------------------------------------------------
module d8ra_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  d8ra_pkg::t_dp_cmd            i_dp_cmd,
    input  logic [d8ra_pkg::SCALE_W-1:0] i_flow_scale,
    input  logic [d8ra_pkg::CIDX_W-1:0]  i_cell_index,
    input  logic [d8ra_pkg::DEPTH_W-1:0] i_runoff_depth,
    input  logic [d8ra_pkg::AREA_W-1:0]  i_cell_area,
    input  logic [d8ra_pkg::SUB_W-1:0]   i_subbasin,
    input  logic [d8ra_pkg::SUB_W-1:0]   i_reach,
    output logic                         o_valid,
    output logic                         o_kind,
    output logic [d8ra_pkg::CIDX_W-1:0]  o_index,
    output logic [d8ra_pkg::FLOW_W-1:0]  o_flow
);

    // open cell state
    logic [d8ra_pkg::CIDX_W-1:0] r_open_index;
    logic [d8ra_pkg::SUB_W-1:0]  r_open_basin;
    logic [d8ra_pkg::SUB_W-1:0]  r_open_reach;
    logic [d8ra_pkg::FLOW_W-1:0] r_open_flow;
    logic                        r_open_wet;
    logic                        r_open_cell_ok;
    logic                        r_open_reach_ok;

    // multiplier chain
    logic [d8ra_pkg::PROD_W-1:0] r_prod;
    logic [d8ra_pkg::MHI_W-1:0]  r_mhi;
    logic [d8ra_pkg::LO_W-1:0]   r_mlo;
    logic [d8ra_pkg::MLO_W-1:0]  mlo_full;
    logic [d8ra_pkg::MHI_W:0]    q_sum;
    logic [d8ra_pkg::FLOW_W-1:0] q_sat;

    // sums
    logic [d8ra_pkg::MAX_BASINS-1:0] r_bvalid;
    logic [d8ra_pkg::FLOW_W-1:0]     r_ws;

    // per-command flags
    logic                       r_up_ok;
    logic [d8ra_pkg::SUB_W-1:0] r_qidx;
    logic                       r_q_ok;

    // result register
    logic                        r_valid;
    logic                        r_kind;
    logic [d8ra_pkg::CIDX_W-1:0] r_index;
    logic [d8ra_pkg::FLOW_W-1:0] r_flow;

    // table ports
    logic                          cell_we;
    logic [d8ra_pkg::CELL_AW-1:0]  cell_waddr, cell_raddr;
    logic [d8ra_pkg::CELL_W-1:0]   cell_wdata, cell_rdata;
    logic [d8ra_pkg::FLOW_W-1:0]   up_flow;
    logic [d8ra_pkg::SUB_W-1:0]    up_basin;
    logic                          up_wet;
    logic                          bas_we;
    logic [d8ra_pkg::BASIN_AW-1:0] bas_waddr, bas_raddr, q_addr;
    logic [d8ra_pkg::FLOW_W-1:0]   bas_wdata, bas_rdata, bas_old;

    assign cell_we    = i_dp_cmd.acc_close && r_open_cell_ok;
    assign cell_waddr = d8ra_pkg::CELL_AW'(r_open_index);
    assign cell_wdata = {r_open_flow, r_open_basin, r_open_wet};
    assign cell_raddr = d8ra_pkg::CELL_AW'(i_cell_index);
    assign {up_flow, up_basin, up_wet} = cell_rdata;

    d8ra_ram #(
        .WIDTH (d8ra_pkg::CELL_W),
        .DEPTH (d8ra_pkg::MAX_CELLS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_waddr),
        .i_wdata (cell_wdata),
        .i_raddr (cell_raddr),
        .o_rdata (cell_rdata)
    );

    assign bas_raddr = i_dp_cmd.acc_query ? d8ra_pkg::BASIN_AW'(i_subbasin)
                                          : d8ra_pkg::BASIN_AW'(r_open_reach);
    assign bas_waddr = d8ra_pkg::BASIN_AW'(r_open_reach);
    assign bas_old   = r_bvalid[bas_waddr] ? bas_rdata : '0;
    assign bas_wdata = d8ra_pkg::sat_add(bas_old, r_open_flow);
    assign bas_we    = i_dp_cmd.st_close && r_open_reach_ok;
    assign q_addr    = d8ra_pkg::BASIN_AW'(r_qidx);

    d8ra_ram #(
        .WIDTH (d8ra_pkg::FLOW_W),
        .DEPTH (d8ra_pkg::MAX_BASINS)
    ) u_basin_ram (
        .i_clk   (i_clk),
        .i_we    (bas_we),
        .i_waddr (bas_waddr),
        .i_wdata (bas_wdata),
        .i_raddr (bas_raddr),
        .o_rdata (bas_rdata)
    );

    // low half product, only its upper word is kept
    assign mlo_full = d8ra_pkg::MLO_W'(r_prod[d8ra_pkg::LO_W-1:0])
                    * d8ra_pkg::MLO_W'(i_flow_scale);
    assign q_sum    = {1'b0, r_mhi} + (d8ra_pkg::MHI_W + 1)'(r_mlo);
    assign q_sat    = (q_sum[d8ra_pkg::MHI_W:d8ra_pkg::FLOW_W] != '0)
                    ? d8ra_pkg::FLOW_MAX : q_sum[d8ra_pkg::FLOW_W-1:0];

    // multiplier pipeline, command flags and result payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.acc_open) begin
            r_prod <= d8ra_pkg::PROD_W'(i_runoff_depth) * d8ra_pkg::PROD_W'(i_cell_area);
        end
        if (i_dp_cmd.st_mul) begin
            r_mhi <= d8ra_pkg::MHI_W'(r_prod[d8ra_pkg::PROD_W-1:d8ra_pkg::LO_W])
                   * d8ra_pkg::MHI_W'(i_flow_scale);
            r_mlo <= mlo_full[d8ra_pkg::MLO_W-1:d8ra_pkg::SCALE_W];
        end
        if (i_dp_cmd.acc_up) begin
            r_up_ok <= (32'(i_cell_index) < 32'(d8ra_pkg::MAX_CELLS));
        end
        if (i_dp_cmd.acc_query) begin
            r_qidx <= i_subbasin;
            r_q_ok <= (32'(i_subbasin) < 32'(d8ra_pkg::MAX_BASINS));
        end
        if (i_dp_cmd.acc_close) begin
            r_kind  <= d8ra_pkg::KIND_CELL;
            r_index <= r_open_index;
            r_flow  <= r_open_flow;
        end else if (i_dp_cmd.st_query) begin
            r_kind  <= d8ra_pkg::KIND_QUERY;
            r_index <= d8ra_pkg::CIDX_W'(r_qidx);
            if (r_qidx == '0) begin
                r_flow <= r_ws;
            end else if (r_q_ok && r_bvalid[q_addr]) begin
                r_flow <= bas_rdata;
            end else begin
                r_flow <= '0;
            end
        end
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_index    <= '0;
            r_open_basin    <= '0;
            r_open_reach    <= '0;
            r_open_flow     <= '0;
            r_open_wet      <= 1'b0;
            r_open_cell_ok  <= 1'b1;
            r_open_reach_ok <= 1'b0;
            r_bvalid        <= '0;
            r_ws            <= '0;
            r_valid         <= 1'b0;
        end else begin
            r_valid <= i_dp_cmd.acc_close || i_dp_cmd.st_query;
            if (i_dp_cmd.acc_open) begin
                r_open_index    <= i_cell_index;
                r_open_basin    <= i_subbasin;
                r_open_reach    <= i_reach;
                r_open_wet      <= (i_runoff_depth != '0);
                r_open_cell_ok  <= (32'(i_cell_index) < 32'(d8ra_pkg::MAX_CELLS));
                r_open_reach_ok <= (i_reach != '0)
                                && (32'(i_reach) < 32'(d8ra_pkg::MAX_BASINS));
            end
            if (i_dp_cmd.st_sum) begin
                r_open_flow <= q_sat;
            end
            if (i_dp_cmd.st_up && r_up_ok && up_wet && (up_basin == r_open_basin)) begin
                r_open_flow <= d8ra_pkg::sat_add(r_open_flow, up_flow);
            end
            if (bas_we) begin
                r_bvalid[bas_waddr] <= 1'b1;
                r_ws <= d8ra_pkg::sat_add(r_ws, r_open_flow);
            end
            if (i_dp_cmd.acc_clear) begin
                r_bvalid <= '0;
                r_ws     <= '0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_index = r_index;
    assign o_flow  = r_flow;

endmodule

// ===== src/d8ra_checker.sv =====
// ----------------------------------------------------------------------------
// d8ra_checker
// port level checks of the d8 runoff accumulator
// ----------------------------------------------------------------------------
module d8ra_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_start,
    input logic [d8ra_pkg::CMD_W-1:0]   i_cmd,
    input logic [d8ra_pkg::SUB_W-1:0]   i_subbasin,
    input logic                         o_busy,
    input logic                         o_valid,
    input logic                         o_kind,
    input logic [d8ra_pkg::CIDX_W-1:0]  o_index
);

    logic acc_close, acc_query, acc_open;

    assign acc_close = i_start && !o_busy && (i_cmd == d8ra_pkg::CMD_CLOSE);
    assign acc_query = i_start && !o_busy && (i_cmd == d8ra_pkg::CMD_QUERY);
    assign acc_open  = i_start && !o_busy && (i_cmd == d8ra_pkg::CMD_OPEN);

    // results come from a close beat in the previous cycle or from a query beat via the query state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(acc_close) || $past(acc_query, 2)))
        else $error("result without a matching command beat");

    // a close answer comes out as a cell flow
    a_close_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(acc_close)) |-> (o_kind == d8ra_pkg::KIND_CELL))
        else $error("close answer not marked as cell flow");

    // query answers carry the basin that was asked for
    a_query_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == d8ra_pkg::KIND_QUERY))
            |-> (o_index == d8ra_pkg::CIDX_W'($past(i_subbasin, 2))))
        else $error("query answer carries wrong basin index");

    // an open occupies the multiplier chain
    a_open_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_open |=> o_busy)
        else $error("open beat did not make the block busy");

    // reset leaves no result and no work in flight
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_busy))
        else $error("activity right after reset");

endmodule

bind d8_runoff_accumulator_core d8ra_checker u_d8ra_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_start    (i_start),
    .i_cmd      (i_cmd),
    .i_subbasin (i_subbasin),
    .o_busy     (o_busy),
    .o_valid    (o_valid),
    .o_kind     (o_kind),
    .o_index    (o_index)
);
